// File: hdl/lorenz_euler_step_defines.svh
`ifndef LORENZ_EULER_STEP_DEFINES_SVH
`define LORENZ_EULER_STEP_DEFINES_SVH

// same-cycle check, sampled on clk and switched off while arst_n is low
`define LES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle check, sampled on clk and switched off while arst_n is low
`define LES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/les_pkg.sv
`default_nettype none

package les_pkg;

	// fixed point: signed Q10.22 in 32 bits
	localparam int QW   = 32;
	localparam int FRAC = 22;
	localparam int PRW  = 2 * QW;

	// field and register widths
	localparam int CW     = 31;
	localparam int DTW    = 23;
	localparam int RNDW   = 10;
	localparam int IDXW   = 3;
	localparam int CFG_DW = 32;

	localparam int NSTG      = 7;
	localparam int SPAWN_STG = 6;

	localparam int RAND_RANGE_DEF = 1000;

	// register indexes
	localparam logic [IDXW-1:0] REG_SIGMA       = 3'd0;
	localparam logic [IDXW-1:0] REG_RHO         = 3'd1;
	localparam logic [IDXW-1:0] REG_BETA        = 3'd2;
	localparam logic [IDXW-1:0] REG_TIME_STEP   = 3'd3;
	localparam logic [IDXW-1:0] REG_TIME_SCALE  = 3'd4;
	localparam logic [IDXW-1:0] REG_PAUSED      = 3'd5;
	localparam logic [IDXW-1:0] REG_SOURCE_SIZE = 3'd6;

	// reset values
	localparam logic [CW-1:0]  SIGMA_RST       = 31'd41943040;
	localparam logic [CW-1:0]  RHO_RST         = 31'd117440512;
	localparam logic [CW-1:0]  BETA_RST        = 31'd11184810;
	localparam logic [DTW-1:0] TIME_STEP_RST   = 23'd41943;
	localparam logic [CW-1:0]  TIME_SCALE_RST  = 31'd4194304;
	localparam logic           PAUSED_RST      = 1'b0;
	localparam logic [CW-1:0]  SOURCE_SIZE_RST = 31'd4194304;

	// a Q product is in range when everything above the kept field is a sign copy
	function automatic logic fits_prod(input logic signed [PRW-1:0] p);
		return (&p[PRW-1:QW+FRAC-1]) || !(|p[PRW-1:QW+FRAC-1]);
	endfunction

	// arithmetic shift of the exact product, i.e. floor
	function automatic logic signed [QW-1:0] qfloor(input logic signed [PRW-1:0] p);
		return p[QW+FRAC-1:FRAC];
	endfunction

	function automatic logic fits_sum(input logic signed [QW:0] s);
		return s[QW] == s[QW-1];
	endfunction

endpackage

`default_nettype wire

// File: hdl/les_spawn.sv
`default_nettype none

// respawn offsets: source_size * (r mod R - R/2) / R, truncated toward zero,
// split as ss = qs*R + rs so every divide is a short reciprocal multiply
module les_spawn #(
	parameter int RAND_RANGE = les_pkg::RAND_RANGE_DEF
) (
	input  logic                                    clk,
	input  logic [les_pkg::SPAWN_STG:1]             ld,
	input  logic [2:0][les_pkg::RNDW-1:0]           rnd,
	input  logic [les_pkg::CW-1:0]                  source_size,
	output logic [2:0][les_pkg::QW-1:0]             spawn
);

	localparam int RW   = $clog2(RAND_RANGE);
	localparam int RNDW = les_pkg::RNDW;
	localparam int CW   = les_pkg::CW;
	localparam int QW   = les_pkg::QW;

	// draw reduction
	localparam int SR  = RNDW + RW;
	localparam int MRW = RNDW + 1;
	localparam int RPW = RNDW + MRW;
	localparam int WD  = RNDW + RW + 1;
	localparam logic [MRW-1:0] MR =
		MRW'(((64'd1 << SR) + 64'(RAND_RANGE) - 64'd1) / 64'(RAND_RANGE));

	// source size split
	localparam int SA  = CW + RW;
	localparam int MAW = CW + 1;
	localparam int QPW = CW + MAW;
	localparam logic [MAW-1:0] MA =
		MAW'(((64'd1 << SA) + 64'(RAND_RANGE) - 64'd1) / 64'(RAND_RANGE));

	// remainder part
	localparam int PW  = 2 * RW;
	localparam int SB  = PW + RW;
	localparam int MBW = PW + 1;
	localparam int PBW = PW + MBW;
	localparam logic [MBW-1:0] MB =
		MBW'(((64'd1 << SB) + 64'(RAND_RANGE) - 64'd1) / 64'(RAND_RANGE));

	localparam logic [RW-1:0] HALF = RW'(RAND_RANGE / 2);
	localparam logic [CW-1:0] RCW  = CW'(RAND_RANGE);

	logic [2:0][RPW-1:0]  rprod;
	logic [2:0][WD-1:0]   remw;
	logic [2:0][RW-1:0]   rem;
	logic [2:0][RW-1:0]   aval;
	logic [2:0]           negv;
	logic [QPW-1:0]       qprod;
	logic [CW-1:0]        rsw;
	logic [2:0][CW-1:0]   qa;
	logic [2:0][PW-1:0]   rsa;
	logic [2:0][PBW-1:0]  pb;
	logic [2:0][RW-1:0]   qb;
	logic [2:0][CW-1:0]   mag;
	logic [2:0][QW-1:0]   sp;

	logic [2:0][RNDW-1:0] rnd_s1;
	logic [2:0][RNDW-1:0] rq_s1;
	logic [CW-1:0]        qs_s1;
	logic [2:0][RW-1:0]   a_s2;
	logic [2:0]           neg_s2;
	logic [CW-1:0]        qs_s2;
	logic [RW-1:0]        rs_s2;
	logic [2:0][CW-1:0]   qa_s3;
	logic [2:0][PW-1:0]   rsa_s3;
	logic [2:0]           neg_s3;
	logic [2:0][PBW-1:0]  pb_s4;
	logic [2:0][CW-1:0]   qa_s4;
	logic [2:0]           neg_s4;
	logic [2:0][QW-1:0]   sp_s5;
	logic [2:0][QW-1:0]   sp_s6;

	always_comb begin
		qprod = QPW'(source_size) * QPW'(MA);
		rsw   = source_size - CW'(qs_s1 * RCW);
		for (int i = 0; i < 3; i++) begin
			rprod[i] = RPW'(rnd[i]) * RPW'(MR);
			remw[i]  = WD'(rnd_s1[i]) - WD'(rq_s1[i]) * WD'(RAND_RANGE);
			rem[i]   = RW'(remw[i]);
			negv[i]  = rem[i] < HALF;
			aval[i]  = negv[i] ? HALF - rem[i] : rem[i] - HALF;
			qa[i]    = CW'(qs_s2 * CW'(a_s2[i]));
			rsa[i]   = PW'(rs_s2) * PW'(a_s2[i]);
			pb[i]    = PBW'(rsa_s3[i]) * PBW'(MB);
			qb[i]    = RW'(pb_s4[i] >> SB);
			mag[i]   = qa_s4[i] + CW'(qb[i]);
			sp[i]    = negv_dummy_free(neg_s4[i], mag[i]);
		end
	end

	function automatic logic [QW-1:0] negv_dummy_free(input logic n, input logic [CW-1:0] m);
		logic [QW-1:0] v;
		v = {1'b0, m};
		return n ? QW'(0) - v : v;
	endfunction

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			for (int i = 0; i < 3; i++) begin
				rnd_s1[i] <= rnd[i];
				rq_s1[i]  <= RNDW'(rprod[i] >> SR);
			end
			qs_s1 <= CW'(qprod >> SA);
		end
		if (ld[2]) begin
			a_s2   <= aval;
			neg_s2 <= negv;
			qs_s2  <= qs_s1;
			rs_s2  <= RW'(rsw);
		end
		if (ld[3]) begin
			qa_s3  <= qa;
			rsa_s3 <= rsa;
			neg_s3 <= neg_s2;
		end
		if (ld[4]) begin
			pb_s4  <= pb;
			qa_s4  <= qa_s3;
			neg_s4 <= neg_s3;
		end
		if (ld[5]) begin
			sp_s5 <= sp;
		end
		if (ld[6]) begin
			sp_s6 <= sp_s5;
		end
	end

	assign spawn = sp_s6;

endmodule

`default_nettype wire

// File: hdl/lorenz_euler_step.sv
`default_nettype none

// One explicit Euler step of the Lorenz system per particle, signed Q10.22.
// Input channel (in_valid/in_stall) carries pos_x/y/z and three draws
// rand_x/y/z; output channel (out_valid/out_stall) returns new_x/y/z and
// respawned. A transaction moves at a rising edge with valid high, stall low.
// Seven register stages; one particle can be taken every cycle unless in_stall
// is high. Each stage holds at most two multiplies (32 by 32 bits) and 33-bit
// adds with their range checks; the respawn offsets run in a shorter parallel
// track whose result feeds the last stage.
// The configuration port (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; indexes 0..6 are sigma, rho, beta, time_step, time_scale, paused,
// source_size, others are ignored. Write it only while the pipe is empty.
// Reset clears every stage valid and loads the default coefficients; nothing
// needs to be swept. When the receiver stalls, a stage only holds if the one
// after it is full, so bubbles close up and in_stall rises once all seven
// stages hold items.
module lorenz_euler_step #(
	parameter int RAND_RANGE = les_pkg::RAND_RANGE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [les_pkg::QW-1:0]     pos_x,
	input  logic signed [les_pkg::QW-1:0]     pos_y,
	input  logic signed [les_pkg::QW-1:0]     pos_z,
	input  logic [les_pkg::RNDW-1:0]          rand_x,
	input  logic [les_pkg::RNDW-1:0]          rand_y,
	input  logic [les_pkg::RNDW-1:0]          rand_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [les_pkg::QW-1:0]     new_x,
	output logic signed [les_pkg::QW-1:0]     new_y,
	output logic signed [les_pkg::QW-1:0]     new_z,
	output logic                              respawned,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [les_pkg::IDXW-1:0]          cfg_index,
	input  logic [les_pkg::CFG_DW-1:0]        cfg_data
);

`include "lorenz_euler_step_defines.svh"

	localparam int QW   = les_pkg::QW;
	localparam int PRW  = les_pkg::PRW;
	localparam int CW   = les_pkg::CW;
	localparam int DTW  = les_pkg::DTW;
	localparam int NSTG = les_pkg::NSTG;

	// configuration registers
	logic [CW-1:0]  sigma_q;
	logic [CW-1:0]  rho_q;
	logic [CW-1:0]  beta_q;
	logic [DTW-1:0] time_step_q;
	logic [CW-1:0]  time_scale_q;
	logic           paused_q;
	logic [CW-1:0]  source_size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q       <= les_pkg::SIGMA_RST;
			rho_q         <= les_pkg::RHO_RST;
			beta_q        <= les_pkg::BETA_RST;
			time_step_q   <= les_pkg::TIME_STEP_RST;
			time_scale_q  <= les_pkg::TIME_SCALE_RST;
			paused_q      <= les_pkg::PAUSED_RST;
			source_size_q <= les_pkg::SOURCE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				les_pkg::REG_SIGMA:       sigma_q       <= cfg_data[CW-1:0];
				les_pkg::REG_RHO:         rho_q         <= cfg_data[CW-1:0];
				les_pkg::REG_BETA:        beta_q        <= cfg_data[CW-1:0];
				les_pkg::REG_TIME_STEP:   time_step_q   <= cfg_data[DTW-1:0];
				les_pkg::REG_TIME_SCALE:  time_scale_q  <= cfg_data[CW-1:0];
				les_pkg::REG_PAUSED:      paused_q      <= cfg_data[0];
				les_pkg::REG_SOURCE_SIZE: source_size_q <= cfg_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// stage valids and per-stage load enables
	logic [NSTG:1]   vld_q;
	logic [NSTG:1]   vld_in;
	logic [NSTG+1:1] en;
	logic            in_acc;
	logic            out_acc;

	always_comb begin
		en[NSTG+1] = !out_stall;
		for (int i = NSTG; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign vld_in   = {vld_q[NSTG-1:1], in_valid};
	assign in_stall = !en[1];
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 1; i <= NSTG; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_in[i];
				end
			end
		end
	end

	// respawn track
	logic [2:0][QW-1:0] spawn;

	les_spawn #(
		.RAND_RANGE (RAND_RANGE)
	) u_spawn (
		.clk         (clk),
		.ld          (en[les_pkg::SPAWN_STG:1]),
		.rnd         ({rand_z, rand_y, rand_x}),
		.source_size (source_size_q),
		.spawn       (spawn)
	);

	logic signed [QW-1:0] kq;
	logic signed [QW-1:0] dtq;

	assign kq  = paused_q ? '0 : $signed({1'b0, time_scale_q});
	assign dtq = $signed({{(QW-DTW){1'b0}}, time_step_q});

	// pipeline registers
	logic signed [QW-1:0]  x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic signed [QW-1:0]  y_s1, y_s2, y_s3, y_s4, y_s5, y_s6;
	logic signed [QW-1:0]  z_s1, z_s2, z_s3, z_s4, z_s5;
	logic signed [QW-1:0]  dxy_s1, drz_s1;
	logic signed [PRW-1:0] pxy_s1, pbz_s1;
	logic signed [PRW-1:0] mx_s2, my_s2;
	logic signed [QW-1:0]  vz_s2;
	logic signed [QW-1:0]  vx_s3, vy_s3;
	logic signed [PRW-1:0] pkz_s3;
	logic signed [PRW-1:0] pkx_s4, pky_s4;
	logic signed [QW-1:0]  wz_s4;
	logic signed [QW-1:0]  wx_s5, wy_s5;
	logic signed [PRW-1:0] pdz_s5;
	logic signed [PRW-1:0] pdx_s6, pdy_s6;
	logic signed [QW-1:0]  nz_s6;
	logic signed [QW-1:0]  nx_s7, ny_s7, nz_s7;
	logic                  ovf_s1, ovf_s2, ovf_s3, ovf_s4, ovf_s5, ovf_s6, ovf_s7;

	// stage logic
	logic signed [QW:0]    sxy1, srz1;
	logic signed [PRW-1:0] pxy1, pbz1;
	logic signed [PRW-1:0] mx2, my2;
	logic signed [QW-1:0]  fxy2, fbz2;
	logic signed [QW:0]    svz2;
	logic signed [QW-1:0]  fmy3;
	logic signed [QW:0]    svy3;
	logic signed [PRW-1:0] pkz3;
	logic signed [PRW-1:0] pkx4, pky4;
	logic signed [PRW-1:0] pdz5;
	logic signed [PRW-1:0] pdx6, pdy6;
	logic signed [QW-1:0]  fz6;
	logic signed [QW:0]    snz6;
	logic signed [QW-1:0]  fx7, fy7;
	logic signed [QW:0]    snx7, sny7;
	logic                  ovf7;

	always_comb begin
		sxy1 = {pos_y[QW-1], pos_y} - {pos_x[QW-1], pos_x};
		srz1 = {2'b00, rho_q} - {pos_z[QW-1], pos_z};
		pxy1 = pos_x * pos_y;
		pbz1 = $signed({1'b0, beta_q}) * pos_z;

		mx2  = $signed({1'b0, sigma_q}) * dxy_s1;
		my2  = x_s1 * drz_s1;
		fxy2 = les_pkg::qfloor(pxy_s1);
		fbz2 = les_pkg::qfloor(pbz_s1);
		svz2 = {fxy2[QW-1], fxy2} - {fbz2[QW-1], fbz2};

		fmy3 = les_pkg::qfloor(my_s2);
		svy3 = {fmy3[QW-1], fmy3} - {y_s2[QW-1], y_s2};
		pkz3 = vz_s2 * kq;

		pkx4 = vx_s3 * kq;
		pky4 = vy_s3 * kq;

		pdz5 = wz_s4 * dtq;

		pdx6 = wx_s5 * dtq;
		pdy6 = wy_s5 * dtq;
		fz6  = les_pkg::qfloor(pdz5_reg_view());
		snz6 = {z_s5[QW-1], z_s5} + {fz6[QW-1], fz6};

		fx7  = les_pkg::qfloor(pdx_s6);
		fy7  = les_pkg::qfloor(pdy_s6);
		snx7 = {x_s6[QW-1], x_s6} + {fx7[QW-1], fx7};
		sny7 = {y_s6[QW-1], y_s6} + {fy7[QW-1], fy7};
		ovf7 = ovf_s6 || !les_pkg::fits_prod(pdx_s6) || !les_pkg::fits_prod(pdy_s6)
			|| !les_pkg::fits_sum(snx7) || !les_pkg::fits_sum(sny7);
	end

	function automatic logic signed [PRW-1:0] pdz5_reg_view();
		return pdz_s5;
	endfunction

	always_ff @(posedge clk) begin
		if (en[1]) begin
			x_s1   <= pos_x;
			y_s1   <= pos_y;
			z_s1   <= pos_z;
			dxy_s1 <= sxy1[QW-1:0];
			drz_s1 <= srz1[QW-1:0];
			pxy_s1 <= pxy1;
			pbz_s1 <= pbz1;
			ovf_s1 <= !les_pkg::fits_sum(sxy1) || !les_pkg::fits_sum(srz1);
		end
		if (en[2]) begin
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			z_s2   <= z_s1;
			mx_s2  <= mx2;
			my_s2  <= my2;
			vz_s2  <= svz2[QW-1:0];
			ovf_s2 <= ovf_s1 || !les_pkg::fits_prod(pxy_s1) || !les_pkg::fits_prod(pbz_s1)
				|| !les_pkg::fits_sum(svz2);
		end
		if (en[3]) begin
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			vx_s3  <= les_pkg::qfloor(mx_s2);
			vy_s3  <= svy3[QW-1:0];
			pkz_s3 <= pkz3;
			ovf_s3 <= ovf_s2 || !les_pkg::fits_prod(mx_s2) || !les_pkg::fits_prod(my_s2)
				|| !les_pkg::fits_sum(svy3);
		end
		if (en[4]) begin
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			z_s4   <= z_s3;
			pkx_s4 <= pkx4;
			pky_s4 <= pky4;
			wz_s4  <= les_pkg::qfloor(pkz_s3);
			ovf_s4 <= ovf_s3 || !les_pkg::fits_prod(pkz_s3);
		end
		if (en[5]) begin
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			z_s5   <= z_s4;
			wx_s5  <= les_pkg::qfloor(pkx_s4);
			wy_s5  <= les_pkg::qfloor(pky_s4);
			pdz_s5 <= pdz5;
			ovf_s5 <= ovf_s4 || !les_pkg::fits_prod(pkx_s4) || !les_pkg::fits_prod(pky_s4);
		end
		if (en[6]) begin
			x_s6   <= x_s5;
			y_s6   <= y_s5;
			pdx_s6 <= pdx6;
			pdy_s6 <= pdy6;
			nz_s6  <= snz6[QW-1:0];
			ovf_s6 <= ovf_s5 || !les_pkg::fits_prod(pdz_s5) || !les_pkg::fits_sum(snz6);
		end
		if (en[7]) begin
			// any range overflow on the way throws the particle back into the cube
			nx_s7  <= ovf7 ? $signed(spawn[0]) : snx7[QW-1:0];
			ny_s7  <= ovf7 ? $signed(spawn[1]) : sny7[QW-1:0];
			nz_s7  <= ovf7 ? $signed(spawn[2]) : nz_s6;
			ovf_s7 <= ovf7;
		end
	end

	assign out_valid = vld_q[NSTG];
	assign new_x     = nx_s7;
	assign new_y     = ny_s7;
	assign new_z     = nz_s7;
	assign respawned = ovf_s7;

	`LES_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall && (&vld_q),
		"input stalled while the pipe still had room")

	`LES_ASSERT_NEXT(a_stall_freezes_pipe, in_stall, $stable(vld_q),
		"stage valids moved while the input was stalled")

	`LES_ASSERT_NOW(a_item_count, $past(arst_n),
		$countones(vld_q) == $past($countones(vld_q)) + int'($past(in_acc))
		- int'($past(out_acc)),
		"items in flight do not match transactions in and out")

endmodule

`default_nettype wire

// File: tb/lorenz_euler_step_tb.sv
`default_nettype none

module lorenz_euler_step_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import les_pkg::*;

	localparam int RR           = RAND_RANGE_DEF;
	localparam int HOLD_CYCLES  = 80;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 30;

	// index with no register behind it, the write must be dropped
	localparam logic [IDXW-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [QW-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [QW-1:0] Q_ONE = 32'sd4194304;

	typedef struct {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic [RNDW-1:0]      rx;
		logic [RNDW-1:0]      ry;
		logic [RNDW-1:0]      rz;
		int                   gap;
	} particle_t;

	typedef struct {
		logic signed [QW-1:0] x;
		logic signed [QW-1:0] y;
		logic signed [QW-1:0] z;
		logic                 spawn;
	} update_t;

	typedef struct {
		logic [CW-1:0]  sigma;
		logic [CW-1:0]  rho;
		logic [CW-1:0]  beta;
		logic [DTW-1:0] time_step;
		logic [CW-1:0]  time_scale;
		logic           paused;
		logic [CW-1:0]  source_size;
	} coeffs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [QW-1:0] pos_x = '0;
	logic signed [QW-1:0] pos_y = '0;
	logic signed [QW-1:0] pos_z = '0;
	logic [RNDW-1:0]      rand_x = '0;
	logic [RNDW-1:0]      rand_y = '0;
	logic [RNDW-1:0]      rand_z = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [QW-1:0] new_x;
	logic signed [QW-1:0] new_y;
	logic signed [QW-1:0] new_z;
	logic                 respawned;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDXW-1:0]      cfg_index = '0;
	logic [CFG_DW-1:0]    cfg_data = '0;

	lorenz_euler_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.rand_x    (rand_x),
		.rand_y    (rand_y),
		.rand_z    (rand_z),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.new_x     (new_x),
		.new_y     (new_y),
		.new_z     (new_z),
		.respawned (respawned),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	coeffs_t   coeffs = '{SIGMA_RST, RHO_RST, BETA_RST, TIME_STEP_RST, TIME_SCALE_RST,
		PAUSED_RST, SOURCE_SIZE_RST};
	particle_t particle_q[$];
	update_t   update_q[$];

	int  items_pushed = 0;
	int  items_taken = 0;
	int  faults = 0;
	int  spawns_seen = 0;
	int  updates_seen = 0;
	int  settings_used = 1;
	int  input_held = 0;
	int  cycles = 0;
	bit  src_calm = 0;
	bit  sink_calm = 0;
	int  hold_reqs = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  stall_left = 0;
	int  gap_left = 0;
	bit  gap_done = 0;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d updates still awaited", cycles,
				update_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// fixed-point helpers for the predictor
	function automatic bit in_q(input longint v);
		return v >= -64'sd2147483648 && v <= 64'sd2147483647;
	endfunction

	function automatic longint qprod(input longint a, input longint b, inout bit ovf);
		longint r;
		r = (a * b) >>> FRAC;
		if (!in_q(r)) begin
			ovf = 1'b1;
			r = 0;
		end
		return r;
	endfunction

	function automatic longint qsum(input longint a, input longint b, inout bit ovf);
		longint r;
		r = a + b;
		if (!in_q(r)) begin
			ovf = 1'b1;
			r = 0;
		end
		return r;
	endfunction

	function automatic longint spawn_at(input logic [RNDW-1:0] r);
		longint off;
		off = longint'(int'(r) % RR) - longint'(RR / 2);
		return (longint'(coeffs.source_size) * off) / longint'(RR);
	endfunction

	function automatic update_t euler_update(input particle_t p);
		longint  x, y, z, k, dt, vx, vy, vz, nx, ny, nz;
		bit      ovf;
		update_t u;
		ovf = 1'b0;
		x = p.x;
		y = p.y;
		z = p.z;
		k = coeffs.paused ? 64'sd0 : longint'(coeffs.time_scale);
		dt = longint'(coeffs.time_step);
		vx = qprod(longint'(coeffs.sigma), qsum(y, -x, ovf), ovf);
		vy = qsum(qprod(x, qsum(longint'(coeffs.rho), -z, ovf), ovf), -y, ovf);
		vz = qsum(qprod(x, y, ovf), -qprod(longint'(coeffs.beta), z, ovf), ovf);
		// velocity is formed before the scale, so a paused step can still overflow
		vx = qprod(vx, k, ovf);
		vy = qprod(vy, k, ovf);
		vz = qprod(vz, k, ovf);
		nx = qsum(x, qprod(vx, dt, ovf), ovf);
		ny = qsum(y, qprod(vy, dt, ovf), ovf);
		nz = qsum(z, qprod(vz, dt, ovf), ovf);
		if (ovf) begin
			nx = spawn_at(p.rx);
			ny = spawn_at(p.ry);
			nz = spawn_at(p.rz);
		end
		u.x = nx[QW-1:0];
		u.y = ny[QW-1:0];
		u.z = nz[QW-1:0];
		u.spawn = ovf;
		return u;
	endfunction

	function automatic void check_field(input string name, input longint want,
		input longint got);
		if (want != got) begin
			faults++;
			if (faults <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
					want, got);
		end
	endfunction

	// sender: one particle per transaction, random gap in front of each
	always @(negedge clk) begin
		particle_t p;
		if (arst_n && (!in_valid || in_fire)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (particle_q.size() > 0 && particle_q[0].gap > 0 && !gap_done) begin
				in_valid <= 1'b0;
				gap_left <= particle_q[0].gap - 1;
				gap_done <= 1'b1;
			end else if (particle_q.size() > 0) begin
				p = particle_q.pop_front();
				pos_x <= p.x;
				pos_y <= p.y;
				pos_z <= p.z;
				rand_x <= p.rx;
				rand_y <= p.ry;
				rand_z <= p.rz;
				in_valid <= 1'b1;
				gap_done <= 1'b0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall drawn after each result, plus the long hold on request
	always @(negedge clk) begin
		int n;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (out_fire) begin
			n = sink_calm ? 0 : $urandom_range(0, 10);
			out_stall <= (n > 0);
			stall_left <= (n > 0) ? n - 1 : 0;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		particle_t p;
		update_t   want;
		in_fire <= in_valid && !in_stall;
		out_fire <= out_valid && !out_stall;
		if (arst_n) begin
			if (in_valid && in_stall)
				input_held++;
			if (out_valid && !out_stall) begin
				if (update_q.size() == 0) begin
					faults++;
					$display("%0t: unexpected result, expected nothing, got %0d %0d %0d %0b",
						$realtime, new_x, new_y, new_z, respawned);
				end else begin
					want = update_q.pop_front();
					check_field("new_x", want.x, new_x);
					check_field("new_y", want.y, new_y);
					check_field("new_z", want.z, new_z);
					check_field("respawned", want.spawn, respawned);
					updates_seen++;
					if (want.spawn)
						spawns_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				p = '{pos_x, pos_y, pos_z, rand_x, rand_y, rand_z, 0};
				update_q.push_back(euler_update(p));
				items_taken++;
			end
		end
	end

	task automatic add_particle(input logic signed [QW-1:0] x, input logic signed [QW-1:0] y,
		input logic signed [QW-1:0] z, input int rx, input int ry, input int rz);
		particle_t p;
		p = '{x, y, z, rx[RNDW-1:0], ry[RNDW-1:0], rz[RNDW-1:0], 0};
		p.gap = src_calm ? 0 : $urandom_range(0, 10);
		particle_q.push_back(p);
		items_pushed++;
	endtask

	function automatic logic signed [QW-1:0] any_coord();
		case ($urandom_range(0, 19))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return '0;
			// mostly moderate magnitudes so that many steps stay in range
			default: return $signed($urandom) >>> $urandom_range(0, 12);
		endcase
	endfunction

	function automatic int any_draw();
		return ($urandom_range(0, 15) == 0) ? $urandom_range(RR, 1023) : $urandom_range(0, RR - 1);
	endfunction

	task automatic add_random(input int count);
		repeat (count)
			add_particle(any_coord(), any_coord(), any_coord(), any_draw(), any_draw(),
				any_draw());
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_taken != items_pushed || update_q.size() != 0);
	endtask

	task automatic write_reg(input logic [IDXW-1:0] idx, input logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_SIGMA:       coeffs.sigma = data[CW-1:0];
			REG_RHO:         coeffs.rho = data[CW-1:0];
			REG_BETA:        coeffs.beta = data[CW-1:0];
			REG_TIME_STEP:   coeffs.time_step = data[DTW-1:0];
			REG_TIME_SCALE:  coeffs.time_scale = data[CW-1:0];
			REG_PAUSED:      coeffs.paused = data[0];
			REG_SOURCE_SIZE: coeffs.source_size = data[CW-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// unused upper bits of each write carry noise
	task automatic program_regs(input coeffs_t c);
		write_reg(REG_SIGMA, {1'($urandom), c.sigma});
		write_reg(REG_RHO, {1'($urandom), c.rho});
		write_reg(REG_BETA, {1'($urandom), c.beta});
		write_reg(REG_TIME_STEP, {9'($urandom), c.time_step});
		write_reg(REG_TIME_SCALE, {1'($urandom), c.time_scale});
		write_reg(REG_PAUSED, {31'($urandom), c.paused});
		write_reg(REG_SOURCE_SIZE, {1'($urandom), c.source_size});
		write_reg(REG_UNUSED, $urandom);
		settings_used++;
	endtask

	initial begin
		coeffs_t c;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// reset coefficients, corners of the position range and of the draws
		add_particle('0, '0, '0, 0, 0, 0);
		add_particle(Q_ONE, Q_ONE, Q_ONE, 500, 500, 500);
		add_particle(Q_MAX, Q_MAX, Q_MAX, 999, 999, 999);
		add_particle(Q_MIN, Q_MIN, Q_MIN, 0, 1000, 1023);
		add_particle(Q_MIN, Q_MAX, '0, 1023, 512, 1);
		add_particle(Q_MAX, Q_MIN, '0, 1, 499, 501);
		add_particle('0, '0, Q_MAX, 341, 682, 1000);
		add_particle(-32'sd1, -32'sd1, -32'sd1, 250, 750, 999);
		add_particle(32'sd1, -32'sd1, 32'sd1, 0, 0, 0);
		add_particle(32'sd41943040, -32'sd14680064, 32'sd83886080, 100, 200, 300);
		add_particle(32'sd83886080, 32'sd83886080, '0, 400, 600, 800);
		add_particle(32'sd125829120, 32'sd125829120, '0, 900, 10, 20);
		add_particle(32'sh55555555, 32'shAAAAAAAA, 32'sh33333333, 682, 341, 1023);
		add_particle(32'shAAAAAAAA, 32'sh55555555, 32'shCCCCCCCC, 1000, 1000, 1000);
		add_particle(-32'sd4194304, 32'sd4194304, -32'sd8388608, 1, 2, 3);
		wait_drained();

		// paused: position holds unless the velocity itself overflows
		c = '{SIGMA_RST, RHO_RST, BETA_RST, TIME_STEP_RST, TIME_SCALE_RST, 1'b1,
			31'd33554432};
		program_regs(c);
		add_particle(Q_ONE, Q_ONE, Q_ONE, 0, 0, 0);
		add_particle(32'sd125829120, 32'sd125829120, '0, 999, 0, 500);
		add_particle(Q_MIN, Q_MAX, '0, 123, 456, 789);
		add_particle(-32'sd20971520, 32'sd8388608, 32'sd12582912, 10, 20, 30);
		add_random(30);
		wait_drained();

		// every register at its top, time step beyond one unit
		c = '{31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 23'h7FFFFF, 31'h7FFFFFFF, 1'b0,
			31'h7FFFFFFF};
		program_regs(c);
		add_random(50);
		wait_drained();

		// every register zero
		c = '{'0, '0, '0, '0, '0, 1'b0, '0};
		program_regs(c);
		add_random(40);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			c.sigma = $urandom_range(0, 1 << 27);
			c.rho = $urandom_range(0, 1 << 28);
			c.beta = $urandom_range(0, 1 << 25);
			c.time_step = $urandom_range(0, 4194304);
			c.time_scale = $urandom_range(0, 1 << 23);
			c.paused = ($urandom_range(0, 3) == 0);
			c.source_size = $urandom;
			program_regs(c);
			src_calm = (ph % 3 == 2);
			sink_calm = (ph % 3 == 1);
			if (ph == 1) begin
				// sender keeps offering back to back while the receiver holds off
				hold_reqs++;
				src_calm = 1;
				add_random(55);
				src_calm = 0;
			end else if (ph == 3) begin
				add_random(25);
				wait_drained();
				add_random(30);
			end else begin
				add_random(55);
			end
			wait_drained();
		end
		src_calm = 0;
		sink_calm = 0;

		wait_drained();
		repeat (20) @(negedge clk);
		$display("checked %0d particle updates under %0d register settings, %0d respawns",
			updates_seen, settings_used, spawns_seen);
		$display("input was held off by the block for %0d cycles in all", input_held);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
